// ===== sv/cer_pkg.sv =====
package cer_pkg;

    localparam int MAX_NODES_DEF = 16;
    localparam int TERM_BITS_DEF = 32;

    localparam int FIELD_W    = 32;
    localparam int ID_W       = 4;
    localparam int VOTE_W     = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_OWN_ID     = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_PEER_COUNT = CFG_IDX_W'(1);

    localparam logic [ID_W-1:0] OWN_ID_RST     = ID_W'(0);
    localparam logic [ID_W-1:0] PEER_COUNT_RST = ID_W'(2);

    typedef enum logic [1:0] {
        MODE_VOTE_REQ   = 2'd0,
        MODE_APPEND     = 2'd1,
        MODE_TIMEOUT    = 2'd2,
        MODE_VOTE_REPLY = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        ROLE_FOLLOWER  = 2'd0,
        ROLE_CANDIDATE = 2'd1,
        ROLE_LEADER    = 2'd2
    } role_t;

    typedef struct packed {
        mode_t              mode;
        logic [FIELD_W-1:0] msg_term;
        logic [ID_W-1:0]    sender_id;
        logic [FIELD_W-1:0] cand_last_term;
        logic [FIELD_W-1:0] cand_last_index;
        logic [FIELD_W-1:0] own_last_term;
        logic [FIELD_W-1:0] own_last_index;
        logic               log_ok;
        logic [FIELD_W-1:0] leader_commit;
        logic               vote_granted;
        logic [FIELD_W-1:0] vote_term;
    } evt_t;

    typedef struct packed {
        logic [FIELD_W-1:0] reply_term;
        logic               grant_ok;
        role_t              role;
        logic               leader_known;
        logic [ID_W-1:0]    leader_node;
        logic [FIELD_W-1:0] commit_point;
        logic               restart_timer;
        logic               start_election;
        logic               became_leader;
    } res_t;

endpackage

// ===== sv/cer_in_stage.sv =====
module cer_in_stage
    import cer_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic evt_valid,
    output logic evt_stall,
    input  evt_t evt,
    input  logic take,
    output logic item_valid,
    output evt_t item
);

    logic valid_reg;
    logic valid_next;
    evt_t item_reg;
    logic accept;

    assign evt_stall  = valid_reg & ~take;
    assign accept     = evt_valid & ~evt_stall;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= evt;
        end
    end

endmodule

// ===== sv/cer_core.sv =====
module cer_core
    import cer_pkg::*;
#(
    parameter int MAX_NODES = MAX_NODES_DEF,
    parameter int TERM_BITS = TERM_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  take,
    input  evt_t                  item,
    output res_t                  res_d
);

    localparam int CMP_W    = (TERM_BITS > FIELD_W) ? TERM_BITS : FIELD_W;
    localparam int VOTE_CAP = (MAX_NODES < 31) ? MAX_NODES : 31;
    localparam logic [VOTE_W-1:0] VOTE_CAP_V = VOTE_W'(VOTE_CAP);
    localparam logic [VOTE_W-1:0] VOTE_ONE   = VOTE_W'(1);

    // node state
    role_t                role_reg, role_next;
    logic [TERM_BITS-1:0] term_reg, term_next;
    logic                 voted_valid_reg, voted_valid_next;
    logic [ID_W-1:0]      voted_node_reg, voted_node_next;
    logic                 leader_valid_reg, leader_valid_next;
    logic [ID_W-1:0]      leader_reg, leader_next;
    logic [VOTE_W-1:0]    vote_count_reg, vote_count_next;
    logic [FIELD_W-1:0]   commit_reg, commit_next;

    logic [ID_W-1:0]      own_id_reg;
    logic [ID_W-1:0]      peer_count_reg;

    // decode
    logic [CMP_W-1:0]     term_max_ext;
    logic [CMP_W-1:0]     msg_ext;
    logic [CMP_W-1:0]     elec_ext;
    logic [CMP_W-1:0]     msg_clip;
    logic [CMP_W-1:0]     elec_clip;
    logic [TERM_BITS-1:0] t_term;
    logic [TERM_BITS-1:0] e_term;
    logic                 higher;
    logic                 not_lower;
    logic                 log_up;
    logic [ID_W:0]        members;
    logic [VOTE_W-1:0]    majority;
    logic [VOTE_W-1:0]    vote_inc;
    logic                 vr_grant;
    logic                 ae_ok;
    logic                 to_go;
    logic                 to_win;
    logic                 rp_ok;
    logic                 rp_down;
    logic                 rp_grant;
    logic                 rp_win;
    logic                 commit_up;
    logic [FIELD_W-1:0]   commit_min;
    logic [CMP_W-1:0]     term_next_ext;

    always_comb
    begin
        for (int i = 0; i < CMP_W; i++)
        begin
            term_max_ext[i] = (i < TERM_BITS);
        end
    end

    // incoming terms saturate at the largest representable term
    assign msg_ext   = CMP_W'(item.msg_term);
    assign elec_ext  = CMP_W'(item.vote_term);
    assign msg_clip  = (msg_ext > term_max_ext) ? term_max_ext : msg_ext;
    assign elec_clip = (elec_ext > term_max_ext) ? term_max_ext : elec_ext;
    assign t_term    = msg_clip[TERM_BITS-1:0];
    assign e_term    = elec_clip[TERM_BITS-1:0];

    assign higher    = t_term > term_reg;
    assign not_lower = t_term >= term_reg;

    assign log_up = (item.cand_last_term > item.own_last_term)
                  || ((item.cand_last_term == item.own_last_term)
                      && (item.cand_last_index >= item.own_last_index));

    assign members  = {1'b0, peer_count_reg} + (ID_W+1)'(1);
    assign majority = VOTE_W'(members >> 1) + VOTE_ONE;
    assign vote_inc = (vote_count_reg < VOTE_CAP_V) ? vote_count_reg + VOTE_ONE
                                                    : vote_count_reg;

    assign vr_grant = (item.mode == MODE_VOTE_REQ) && not_lower
                    && (higher || !voted_valid_reg || (voted_node_reg == item.sender_id))
                    && log_up;
    assign ae_ok    = (item.mode == MODE_APPEND) && not_lower;
    assign to_go    = (item.mode == MODE_TIMEOUT) && (role_reg != ROLE_LEADER);
    assign to_win   = to_go && (VOTE_ONE >= majority);
    assign rp_ok    = (item.mode == MODE_VOTE_REPLY) && (role_reg == ROLE_CANDIDATE)
                    && (term_reg == e_term);
    assign rp_down  = rp_ok && higher;
    assign rp_grant = rp_ok && !higher && item.vote_granted;
    assign rp_win   = rp_grant && (vote_inc >= majority);

    assign commit_up  = item.log_ok && (item.leader_commit > commit_reg);
    assign commit_min = (item.leader_commit < item.own_last_index) ? item.leader_commit
                                                                   : item.own_last_index;

    // next state
    always_comb
    begin
        role_next         = role_reg;
        term_next         = term_reg;
        voted_valid_next  = voted_valid_reg;
        voted_node_next   = voted_node_reg;
        leader_valid_next = leader_valid_reg;
        leader_next       = leader_reg;
        vote_count_next   = vote_count_reg;
        commit_next       = commit_reg;

        unique case (item.mode)
            MODE_VOTE_REQ:
            begin
                if (higher)
                begin
                    term_next         = t_term;
                    role_next         = ROLE_FOLLOWER;
                    voted_valid_next  = 1'b0;
                    voted_node_next   = '0;
                    leader_valid_next = 1'b0;
                    leader_next       = '0;
                    vote_count_next   = '0;
                end
                if (vr_grant)
                begin
                    voted_valid_next = 1'b1;
                    voted_node_next  = item.sender_id;
                end
            end
            MODE_APPEND:
            begin
                if (ae_ok)
                begin
                    if (higher)
                    begin
                        term_next        = t_term;
                        voted_valid_next = 1'b0;
                        voted_node_next  = '0;
                    end
                    role_next         = ROLE_FOLLOWER;
                    vote_count_next   = '0;
                    leader_valid_next = 1'b1;
                    leader_next       = item.sender_id;
                    if (commit_up)
                    begin
                        commit_next = commit_min;
                    end
                end
            end
            MODE_TIMEOUT:
            begin
                if (to_go)
                begin
                    role_next = ROLE_CANDIDATE;
                    if (term_reg != '1)
                    begin
                        term_next = term_reg + TERM_BITS'(1);
                    end
                    voted_valid_next = 1'b1;
                    voted_node_next  = own_id_reg;
                    vote_count_next  = VOTE_ONE;
                    if (to_win)
                    begin
                        role_next         = ROLE_LEADER;
                        leader_valid_next = 1'b1;
                        leader_next       = own_id_reg;
                    end
                end
            end
            MODE_VOTE_REPLY:
            begin
                if (rp_down)
                begin
                    term_next         = t_term;
                    role_next         = ROLE_FOLLOWER;
                    voted_valid_next  = 1'b0;
                    voted_node_next   = '0;
                    leader_valid_next = 1'b0;
                    leader_next       = '0;
                    vote_count_next   = '0;
                end
                else if (rp_grant)
                begin
                    vote_count_next = vote_inc;
                    if (rp_win)
                    begin
                        role_next         = ROLE_LEADER;
                        leader_valid_next = 1'b1;
                        leader_next       = own_id_reg;
                    end
                end
            end
        endcase
    end

    assign term_next_ext = CMP_W'(term_next);

    // result item
    always_comb
    begin
        res_d.reply_term     = term_next_ext[FIELD_W-1:0];
        res_d.grant_ok       = vr_grant | (ae_ok & item.log_ok);
        res_d.role           = role_next;
        res_d.leader_known   = leader_valid_next;
        res_d.leader_node    = leader_valid_next ? leader_next : '0;
        res_d.commit_point   = commit_next;
        res_d.restart_timer  = vr_grant | ae_ok | to_go | rp_down;
        res_d.start_election = to_go;
        res_d.became_leader  = to_win | rp_win;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            role_reg         <= ROLE_FOLLOWER;
            term_reg         <= '0;
            voted_valid_reg  <= 1'b0;
            voted_node_reg   <= '0;
            leader_valid_reg <= 1'b0;
            leader_reg       <= '0;
            vote_count_reg   <= '0;
            commit_reg       <= '0;
        end
        else if (take)
        begin
            role_reg         <= role_next;
            term_reg         <= term_next;
            voted_valid_reg  <= voted_valid_next;
            voted_node_reg   <= voted_node_next;
            leader_valid_reg <= leader_valid_next;
            leader_reg       <= leader_next;
            vote_count_reg   <= vote_count_next;
            commit_reg       <= commit_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_id_reg     <= OWN_ID_RST;
            peer_count_reg <= PEER_COUNT_RST;
        end
        else if (cfg_write)
        begin
            if (cfg_index == CFG_OWN_ID)
            begin
                own_id_reg <= ID_W'(cfg_data);
            end
            else if (cfg_index == CFG_PEER_COUNT)
            begin
                peer_count_reg <= ID_W'(cfg_data);
            end
        end
    end

endmodule

// ===== sv/cer_out_stage.sv =====
module cer_out_stage
    import cer_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic take,
    input  res_t res_d,
    output logic can_load,
    output logic res_valid,
    input  logic res_stall,
    output res_t res
);

    logic valid_reg;
    logic valid_next;
    res_t res_reg;

    assign can_load  = ~valid_reg | ~res_stall;
    assign res_valid = valid_reg;
    assign res       = res_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (!res_stall)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            res_reg <= res_d;
        end
    end

endmodule

// ===== sv/consensus_election_role_machine.sv =====
// An accepted item waits in the input register until it is taken; the role/term
// update then writes its result item into the result register, which drives res.
// Throughput: one item per cycle while res_stall is low; the role/term update is
// one pass between input and result register, so items may follow back to back.
// Reset (rst_n, async, active low): follower, term 0, no vote, no leader,
// vote count 0, commit 0; own_id 0, peer_count 2; both item registers empty.
module consensus_election_role_machine
    import cer_pkg::*;
#(
    parameter int MAX_NODES = MAX_NODES_DEF,
    parameter int TERM_BITS = TERM_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  evt_valid,
    output logic                  evt_stall,
    input  evt_t                  evt,
    output logic                  res_valid,
    input  logic                  res_stall,
    output res_t                  res,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic item_valid;
    evt_t item;
    logic can_load;
    logic take;
    res_t res_d;

    assign cfg_ready = 1'b1;
    assign take      = item_valid & can_load;

    cer_in_stage u_in
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .evt_valid  (evt_valid),
        .evt_stall  (evt_stall),
        .evt        (evt),
        .take       (take),
        .item_valid (item_valid),
        .item       (item)
    );

    cer_core #(
        .MAX_NODES (MAX_NODES),
        .TERM_BITS (TERM_BITS)
    ) u_core
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_valid & cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .take      (take),
        .item      (item),
        .res_d     (res_d)
    );

    cer_out_stage u_out
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (take),
        .res_d     (res_d),
        .can_load  (can_load),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res)
    );

endmodule

// ===== sv/cer_checker.sv =====
module cer_checker
    import cer_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic res_valid,
    input logic res_stall,
    input res_t res
);

    // a stalled result item holds
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(res))
        else $error("result item changed while stalled");

    a_win_is_leader: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.became_leader |->
            res.role == ROLE_LEADER && res.leader_known && !res.grant_ok)
        else $error("became_leader without leader role");

    a_elect_restart: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.start_election |->
            res.restart_timer && res.role != ROLE_FOLLOWER)
        else $error("election start without timer restart");

    // a node may grant its own request while candidate or leader
    a_grant_restart: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.grant_ok |-> res.restart_timer)
        else $error("grant without timer restart");

    a_no_leader_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res.leader_known |-> res.leader_node == '0)
        else $error("leader_node set while no leader known");

endmodule

bind consensus_election_role_machine cer_checker u_cer_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
);

// ===== sim/cer_vote_checker.sv =====
module cer_vote_checker
    import cer_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  evt_valid,
    input  logic                  evt_stall,
    input  evt_t                  evt,
    input  logic                  res_valid,
    input  logic                  res_stall,
    input  res_t                  res,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    fail_count,
    output int                    in_flight,
    output int                    evts_seen,
    output logic [FIELD_W-1:0]    term_now
);

    localparam int VOTE_CAP = (MAX_NODES_DEF < 31) ? MAX_NODES_DEF : 31;
    localparam logic [FIELD_W-1:0] TERM_TOP = '1;

    // predicted node state
    role_t              node_role;
    logic [FIELD_W-1:0] node_term;
    logic               vote_cast;
    logic [ID_W-1:0]    vote_for;
    logic               ldr_known;
    logic [ID_W-1:0]    ldr_id;
    logic [VOTE_W-1:0]  votes_won;
    logic [FIELD_W-1:0] commit_idx;
    logic [ID_W-1:0]    cfg_own_id;
    logic [ID_W-1:0]    cfg_peers;

    res_t pending_outcomes[$];

    assign term_now = node_term;

    function automatic int quorum();
        return (int'(cfg_peers) + 1) / 2 + 1;
    endfunction

    function automatic void demote(logic [FIELD_W-1:0] t);
        node_term = t;
        node_role = ROLE_FOLLOWER;
        vote_cast = 1'b0;
        vote_for  = '0;
        ldr_known = 1'b0;
        ldr_id    = '0;
        votes_won = '0;
    endfunction

    function automatic void take_lead();
        node_role = ROLE_LEADER;
        ldr_known = 1'b1;
        ldr_id    = cfg_own_id;
    endfunction

    function automatic res_t apply_event(evt_t e);
        res_t r;
        logic up_to_date;
        r = '0;
        case (e.mode)
            MODE_VOTE_REQ:
            begin
                if (e.msg_term > node_term)
                    demote(e.msg_term);
                if (e.msg_term == node_term && (!vote_cast || vote_for == e.sender_id))
                begin
                    up_to_date = (e.cand_last_term > e.own_last_term) ||
                                 (e.cand_last_term == e.own_last_term &&
                                  e.cand_last_index >= e.own_last_index);
                    if (up_to_date)
                    begin
                        r.grant_ok      = 1'b1;
                        r.restart_timer = 1'b1;
                        vote_cast       = 1'b1;
                        vote_for        = e.sender_id;
                    end
                end
            end
            MODE_APPEND:
            begin
                if (e.msg_term >= node_term)
                begin
                    if (e.msg_term > node_term)
                        demote(e.msg_term);
                    node_role       = ROLE_FOLLOWER;
                    votes_won       = '0;
                    ldr_known       = 1'b1;
                    ldr_id          = e.sender_id;
                    r.restart_timer = 1'b1;
                    r.grant_ok      = e.log_ok;
                    if (e.log_ok && e.leader_commit > commit_idx)
                        commit_idx = (e.leader_commit < e.own_last_index) ?
                                     e.leader_commit : e.own_last_index;
                end
            end
            MODE_TIMEOUT:
            begin
                // a leader ignores its election timer
                if (node_role != ROLE_LEADER)
                begin
                    node_role = ROLE_CANDIDATE;
                    if (node_term != TERM_TOP)
                        node_term = node_term + 1'b1;
                    vote_cast        = 1'b1;
                    vote_for         = cfg_own_id;
                    votes_won        = VOTE_W'(1);
                    r.restart_timer  = 1'b1;
                    r.start_election = 1'b1;
                    if (int'(votes_won) >= quorum())
                    begin
                        take_lead();
                        r.became_leader = 1'b1;
                    end
                end
            end
            default:
            begin
                if (node_role == ROLE_CANDIDATE && node_term == e.vote_term)
                begin
                    if (e.msg_term > node_term)
                    begin
                        demote(e.msg_term);
                        r.restart_timer = 1'b1;
                    end
                    else if (e.vote_granted)
                    begin
                        if (int'(votes_won) < VOTE_CAP)
                            votes_won = votes_won + 1'b1;
                        if (int'(votes_won) >= quorum())
                        begin
                            take_lead();
                            r.became_leader = 1'b1;
                        end
                    end
                end
            end
        endcase
        r.reply_term   = node_term;
        r.role         = node_role;
        r.leader_known = ldr_known;
        r.leader_node  = ldr_known ? ldr_id : '0;
        r.commit_point = commit_idx;
        return r;
    endfunction

    function automatic void check_field(string name, logic [FIELD_W-1:0] want,
                                        logic [FIELD_W-1:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected %0h, actual %0h", name, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        res_t want;
        if (!rst_n)
        begin
            cfg_own_id = OWN_ID_RST;
            cfg_peers  = PEER_COUNT_RST;
            demote('0);
            commit_idx = '0;
            pending_outcomes.delete();
            evts_seen  = 0;
            in_flight  = 0;
            fail_count = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_OWN_ID)
                    cfg_own_id = cfg_data;
                else if (cfg_index == CFG_PEER_COUNT)
                    cfg_peers = cfg_data;
            end
            if (evt_valid && !evt_stall)
            begin
                pending_outcomes.insert(pending_outcomes.size(), apply_event(evt));
                evts_seen++;
            end
            if (res_valid && !res_stall)
            begin
                if (pending_outcomes.size() == 0)
                begin
                    $error("result item arrived with nothing expected");
                    fail_count++;
                end
                else
                begin
                    want = pending_outcomes.pop_front();
                    check_field("reply_term", want.reply_term, res.reply_term);
                    check_field("grant_ok", 32'(want.grant_ok), 32'(res.grant_ok));
                    check_field("role", 32'(want.role), 32'(res.role));
                    check_field("leader_known", 32'(want.leader_known), 32'(res.leader_known));
                    check_field("leader_node", 32'(want.leader_node), 32'(res.leader_node));
                    check_field("commit_point", want.commit_point, res.commit_point);
                    check_field("restart_timer", 32'(want.restart_timer),
                                32'(res.restart_timer));
                    check_field("start_election", 32'(want.start_election),
                                32'(res.start_election));
                    check_field("became_leader", 32'(want.became_leader),
                                32'(res.became_leader));
                end
            end
            in_flight = pending_outcomes.size();
        end
    end

endmodule

// ===== sim/tb_consensus_election_role_machine.sv =====
module tb_consensus_election_role_machine;
    import cer_pkg::*;

    localparam int IDLE_LIMIT = 3000;
    localparam int PHASES     = 6;
    localparam logic [FIELD_W-1:0] TERM_TOP = '1;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  evt_valid = 1'b0;
    logic                  evt_stall;
    evt_t                  evt = '0;
    logic                  res_valid;
    logic                  res_stall = 1'b0;
    res_t                  res;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    int                 fail_count;
    int                 in_flight;
    int                 evts_seen;
    logic [FIELD_W-1:0] term_now;

    int evts_sent = 0;
    int burst_left = 0;
    int idle_cycles = 0;
    int stall_style = 0;
    int style_left = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    consensus_election_role_machine dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .evt_valid (evt_valid),
        .evt_stall (evt_stall),
        .evt       (evt),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    cer_vote_checker checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .evt_valid  (evt_valid),
        .evt_stall  (evt_stall),
        .evt        (evt),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .res        (res),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .in_flight  (in_flight),
        .evts_seen  (evts_seen),
        .term_now   (term_now)
    );

    // result side: the stall style (no stall, light or heavy stalling) is redrawn when its run ends
    always @(posedge clk)
    begin
        if (style_left == 0)
        begin
            stall_style <= $urandom_range(2);
            style_left  <= $urandom_range(300, 50);
        end
        else
            style_left <= style_left - 1;
        if (stall_style == 0)
            res_stall <= 1'b0;
        else if (stall_style == 1)
            res_stall <= ($urandom_range(3) == 0);
        else
            res_stall <= ($urandom_range(9) < 7);
    end

    always @(posedge clk)
    begin
        if ((evt_valid && !evt_stall) || (res_valid && !res_stall) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic evt_t make_event(mode_t m, logic [FIELD_W-1:0] t, logic [ID_W-1:0] s);
        evt_t e;
        e.mode            = m;
        e.msg_term        = t;
        e.sender_id       = s;
        e.cand_last_term  = $urandom;
        e.cand_last_index = $urandom;
        e.own_last_term   = $urandom;
        e.own_last_index  = $urandom;
        e.log_ok          = 1'($urandom_range(1));
        e.leader_commit   = $urandom;
        e.vote_granted    = 1'($urandom_range(1));
        e.vote_term       = $urandom;
        return e;
    endfunction

    // mostly the current term, sometimes ahead, stale or anywhere
    function automatic logic [FIELD_W-1:0] near_term(logic [FIELD_W-1:0] h);
        int r;
        r = $urandom_range(19);
        if (r < 10)
            return h;
        else if (r < 13)
            return h + 1'b1;
        else if (r < 14)
            return h + $urandom_range(5, 2);
        else if (r < 16)
            return (h > 3) ? h - $urandom_range(3, 1) : '0;
        else if (r < 18)
            return $urandom_range(h);
        else
            return $urandom;
    endfunction

    task automatic push_event(evt_t e);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(2) == 0) ? 0 : $urandom_range(8, 1);
            if (gap != 0)
            begin
                evt_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(24, 1);
        end
        burst_left--;
        evt       <= e;
        evt_valid <= 1'b1;
        do @(posedge clk); while (evt_stall);
        evts_sent++;
        // let the checker take this item in so the term hint is current
        wait (evts_seen == evts_sent);
    endtask

    task automatic settle();
        evt_valid <= 1'b0;
        burst_left = 0;
        do @(negedge clk); while (in_flight != 0);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
    endtask

    task automatic set_config(logic [ID_W-1:0] own, logic [ID_W-1:0] peers);
        write_reg(CFG_OWN_ID, own);
        write_reg(CFG_PEER_COUNT, peers);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_directed();
        evt_t e;
        e = make_event(MODE_VOTE_REQ, '0, 4'd3);
        e.cand_last_term = '0;
        e.own_last_term = '0;
        e.cand_last_index = 32'd5;
        e.own_last_index = 32'd5;
        push_event(e);
        e.sender_id = 4'd5;                 // already voted for another node
        push_event(e);
        e.sender_id = 4'd3;
        e.cand_last_term = 32'd2;
        e.own_last_term = 32'd3;            // candidate log behind
        push_event(e);
        e = make_event(MODE_APPEND, '0, 4'd4);
        e.log_ok = 1'b0;
        push_event(e);
        e.log_ok = 1'b1;
        e.leader_commit = 32'd10;
        e.own_last_index = 32'd7;
        push_event(e);
        e.leader_commit = 32'd5;
        push_event(e);
        push_event(make_event(MODE_TIMEOUT, '0, '0));
        e = make_event(MODE_VOTE_REPLY, 32'd1, 4'd2);
        e.vote_term = '0;                   // stale election
        e.vote_granted = 1'b1;
        push_event(e);
        e.vote_term = 32'd1;
        push_event(e);
        push_event(make_event(MODE_TIMEOUT, '1, '1));
        push_event(e);                      // reply while leader
        e = make_event(MODE_APPEND, '0, 4'd6);
        e.log_ok = 1'b1;                    // stale leader
        push_event(e);
        e = make_event(MODE_VOTE_REQ, 32'd5, 4'd9);
        e.cand_last_term = '1;
        e.own_last_term = '1;
        e.cand_last_index = '1;
        e.own_last_index = '1;
        push_event(e);
        push_event(make_event(MODE_TIMEOUT, '0, '0));
        e = make_event(MODE_VOTE_REPLY, 32'd9, 4'd1);
        e.vote_term = 32'd6;                // higher-term reply
        push_event(e);
        push_event(make_event(MODE_TIMEOUT, '0, '0));
        e = make_event(MODE_VOTE_REPLY, 32'd10, 4'd1);
        e.vote_term = 32'd10;
        e.vote_granted = 1'b0;
        push_event(e);
        e = make_event(MODE_VOTE_REQ, 32'd12, 4'd2);
        e.cand_last_term = '0;
        e.own_last_term = 32'd1;
        push_event(e);
        e = make_event(MODE_VOTE_REQ, 32'd12, 4'd7);
        e.cand_last_term = 32'd4;
        e.own_last_term = 32'd3;
        e.cand_last_index = '0;
        e.own_last_index = '1;
        push_event(e);
        e = make_event(MODE_APPEND, 32'd20, '1);
        e.log_ok = 1'b1;
        e.leader_commit = '1;
        e.own_last_index = 32'h8000_0000;
        push_event(e);
    endtask

    task automatic run_traffic(int n);
        evt_t e;
        int sent;
        int r;
        int k;
        sent = 0;
        while (sent < n)
        begin
            r = $urandom_range(39);
            if (r < 14)
            begin
                push_event(make_event(MODE_TIMEOUT, $urandom, 4'($urandom_range(15))));
                sent++;
                k = $urandom_range(12, 1);
                repeat (k)
                begin
                    e = make_event(MODE_VOTE_REPLY, term_now, 4'($urandom_range(15)));
                    r = $urandom_range(19);
                    if (r == 0)
                        e.msg_term = term_now + $urandom_range(3, 1);
                    else if (r == 1)
                        e.msg_term = $urandom;
                    else if (r == 2)
                        e.msg_term = $urandom_range(term_now);
                    e.vote_term = ($urandom_range(9) == 0) ? near_term(term_now) : term_now;
                    e.vote_granted = ($urandom_range(3) != 0);
                    push_event(e);
                    sent++;
                end
            end
            else if (r < 24)
            begin
                k = $urandom_range(6, 1);
                repeat (k)
                begin
                    e = make_event(MODE_APPEND, near_term(term_now), 4'($urandom_range(15)));
                    e.log_ok = ($urandom_range(3) != 0);
                    if ($urandom_range(7) != 0)
                    begin
                        e.leader_commit = $urandom_range(400);
                        e.own_last_index = $urandom_range(400);
                    end
                    push_event(e);
                    sent++;
                end
            end
            else if (r < 32)
            begin
                k = $urandom_range(3, 1);
                repeat (k)
                begin
                    e = make_event(MODE_VOTE_REQ, near_term(term_now),
                                   4'(($urandom_range(2) == 0) ? $urandom_range(15)
                                                               : $urandom_range(2, 1)));
                    if ($urandom_range(1) == 0)
                        e.own_last_term = $urandom_range(50);
                    r = $urandom_range(3);
                    if (r == 0)
                        e.cand_last_term = e.own_last_term + 1'b1;
                    else if (r == 1)
                        e.cand_last_term = e.own_last_term - 1'b1;
                    else if (r == 2)
                        e.cand_last_term = e.own_last_term;
                    r = $urandom_range(3);
                    if (r == 0)
                        e.cand_last_index = e.own_last_index + 1'b1;
                    else if (r == 1)
                        e.cand_last_index = e.own_last_index - 1'b1;
                    else if (r == 2)
                        e.cand_last_index = e.own_last_index;
                    push_event(e);
                    sent++;
                end
            end
            else if (r < 39)
            begin
                // noise, not counted
                e = make_event(mode_t'($urandom_range(3)), $urandom, 4'($urandom_range(15)));
                if ($urandom_range(1) == 0)
                    e.msg_term = near_term(term_now);
                push_event(e);
            end
            else
                settle();
        end
    endtask

    // the term never comes down from its ceiling, so this part runs last
    task automatic run_term_ceiling();
        evt_t e;
        e = make_event(MODE_APPEND, TERM_TOP, 4'd3);
        push_event(e);
        push_event(make_event(MODE_TIMEOUT, '0, '0));
        e = make_event(MODE_VOTE_REPLY, TERM_TOP, 4'd8);
        e.vote_term = TERM_TOP;
        e.vote_granted = 1'b1;
        push_event(e);
        push_event(make_event(MODE_TIMEOUT, '0, '0));
        e = make_event(MODE_APPEND, TERM_TOP, 4'd11);
        push_event(e);
        push_event(make_event(MODE_TIMEOUT, '0, '0));
        e = make_event(MODE_VOTE_REQ, TERM_TOP, 4'd5);   // own vote, same node asks
        e.cand_last_term = '1;
        e.own_last_term = '0;
        push_event(e);
        e.sender_id = 4'd9;
        push_event(e);
        e = make_event(MODE_VOTE_REPLY, TERM_TOP, 4'd8);
        e.vote_term = TERM_TOP;
        e.vote_granted = 1'b0;
        push_event(e);
        run_traffic(40);
    endtask

    initial
    begin
        logic [ID_W-1:0] own;
        logic [ID_W-1:0] peers;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        run_directed();
        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0:
                begin
                    own = 4'd15;
                    peers = 4'd0;
                end
                1:
                begin
                    own = 4'd0;
                    peers = 4'd15;
                end
                2:
                begin
                    own = 4'd7;
                    peers = 4'd1;
                end
                3:
                begin
                    own = 4'd15;
                    peers = 4'd2;
                end
                4:
                begin
                    own = 4'd3;
                    peers = 4'd15;
                end
                default:
                begin
                    own = 4'($urandom_range(15));
                    peers = 4'($urandom_range(15));
                end
            endcase
            settle();
            set_config(own, peers);
            run_traffic(165);
        end
        settle();
        set_config(4'd5, 4'd2);
        run_term_ceiling();
        evt_valid <= 1'b0;
        do @(negedge clk); while (in_flight != 0);
        repeat (10) @(posedge clk);
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
